FILE: sv/bdm_pkg.sv
// Shared types, constants and the control program of the battery discharge monitor.
package bdm_pkg;

  // Field and datapath widths
  localparam int unsigned MV_W      = 13;
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned RISE_W    = 5;
  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned SPAN_W    = MV_W + 1;
  localparam int unsigned ELAPSED_W = SEC_W + 1;
  localparam int unsigned DEN_W     = SEC_W + MV_W;
  localparam int unsigned REM_W     = DEN_W + RATE_W;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned ITER_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Arithmetic constants
  localparam logic [MV_W-1:0]    MV_SCALE     = 13'd4900;  // 2 * 2450 mV full scale
  localparam int unsigned        MV_SHIFT     = 12;        // 4096 converter levels
  localparam logic [LEVEL_W-1:0] LEVEL_SCALE  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
  localparam logic [23:0]        RATE_SCALE   = 24'd8640000; // percent * seconds per day
  localparam logic [RATE_W-1:0]  RATE_MAX     = 8'd255;
  localparam logic [RISE_W-1:0]  RISE_MAX     = 5'd31;
  localparam logic [MV_W-1:0]    MV_OUT_MAX   = 13'd4898;

  // Register reset values
  localparam logic [MV_W-1:0]    FULL_MV_RESET    = 13'd2900;
  localparam logic [MV_W-1:0]    EMPTY_MV_RESET   = 13'd2300;
  localparam logic [LIMIT_W-1:0] RISE_LIMIT_RESET = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_MV    = 2'd0,
    REG_EMPTY_MV   = 2'd1,
    REG_RISE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_sample;
    logic [SEC_W-1:0] now_seconds;
  } bdm_in_t;

  typedef struct packed {
    logic [MV_W-1:0]    voltage_mv;
    logic [LEVEL_W-1:0] level_percent;
    logic               charging;
    logic [RATE_W-1:0]  drain_rate;
    logic               rate_invalid;
  } bdm_out_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_MV,
    OP_UPDATE,
    OP_LVL_LOAD,
    OP_DIV,
    OP_LVL_STORE,
    OP_DEN_MUL,
    OP_NUM_MUL,
    OP_RATE_LOAD,
    OP_RATE_STORE,
    OP_EMIT
  } dp_op_t;

  // Sequencer jump conditions
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_SKIP,
    JMP_WAIT_OUT,
    JMP_GOTO
  } jump_t;

  typedef struct packed {
    dp_op_t              op;
    jump_t               jump;
    logic [STEP_W-1:0]   target;
    logic                load_iter;
    logic [ITER_W-1:0]   iter_init;
  } ctrl_word_t;

  typedef struct packed {
    logic in_req;
    logic out_free;
    logic rate_done;
  } dp_status_t;

  // Step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MV         = 4'd1;
  localparam logic [STEP_W-1:0] STEP_UPDATE     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LVL_LOAD   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LVL_DIV    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LVL_STORE  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DEN_MUL    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_NUM_MUL    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RATE_LOAD  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RATE_DIV   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_RATE_STORE = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd11;

  // Divide loop trip counts, minus one
  localparam logic [ITER_W-1:0] LVL_ITERS  = ITER_W'(LEVEL_W - 1);
  localparam logic [ITER_W-1:0] RATE_ITERS = ITER_W'(RATE_W - 1);

  function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, jump: JMP_NEXT, target: STEP_IDLE, load_iter: 1'b0, iter_init: '0};
    case (addr)
      STEP_IDLE: begin
        w.op   = OP_WAIT_IN;
        w.jump = JMP_WAIT_IN;
      end
      STEP_MV:     w.op = OP_MV;
      STEP_UPDATE: w.op = OP_UPDATE;
      STEP_LVL_LOAD: begin
        w.op        = OP_LVL_LOAD;
        w.load_iter = 1'b1;
        w.iter_init = LVL_ITERS;
      end
      STEP_LVL_DIV: begin
        w.op   = OP_DIV;
        w.jump = JMP_LOOP;
      end
      STEP_LVL_STORE: begin
        w.op     = OP_LVL_STORE;
        w.jump   = JMP_SKIP;
        w.target = STEP_EMIT;
      end
      STEP_DEN_MUL: w.op = OP_DEN_MUL;
      STEP_NUM_MUL: w.op = OP_NUM_MUL;
      STEP_RATE_LOAD: begin
        w.op        = OP_RATE_LOAD;
        w.load_iter = 1'b1;
        w.iter_init = RATE_ITERS;
      end
      STEP_RATE_DIV: begin
        w.op   = OP_DIV;
        w.jump = JMP_LOOP;
      end
      STEP_RATE_STORE: w.op = OP_RATE_STORE;
      STEP_EMIT: begin
        w.op     = OP_EMIT;
        w.jump   = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jump   = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/battery_discharge_monitor.sv
// Top level of the battery discharge monitor: sequencer plus datapath.
//
// One request carries a 12-bit battery converter sample and a time in whole
// seconds; one result comes back for every request with the voltage in mV
// (raw * 4900 / 4096), a 0..100 charge level between the empty and full
// registers, and either a charging flag (reference restarted) or a discharge
// rate in percent per day since the reference, clamped to 0..255. A microcoded
// sequencer walks a twelve-step program over a datapath with one shared
// restoring divide step; one request occupies the block at a time and runs
// 7 level divide steps plus 8 rate divide steps when a rate is computed and
// the level steps alone when the rate is skipped (charging, zero or negative elapsed time,
// full not above empty, or voltage at or above the reference). The finished
// result sits in an output register, so the next request is taken while the
// previous result waits for out_ready; the program stalls only if a second
// result is ready before the first has been taken. Configuration writes are
// always accepted; write them only while no request is in flight.
module battery_discharge_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bdm_pkg::bdm_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdm_pkg::bdm_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdm_pkg::MV_W-1:0]        cfg_data
);

  bdm_pkg::ctrl_word_t ctrl;
  bdm_pkg::dp_status_t status;

  // Register writes are never stalled.
  assign cfg_ready = 1'b1;

  // Fetch one control word per cycle; jump on datapath status.
  bdm_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Execute the control word: convert, track reference, divide, emit.
  bdm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: sv/bdm_sequencer.sv
// Step counter and microcode table that drive the monitor datapath.
module bdm_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  bdm_pkg::dp_status_t   status,
  output bdm_pkg::ctrl_word_t   ctrl
);

  logic [bdm_pkg::STEP_W-1:0] step, step_next;
  logic [bdm_pkg::ITER_W-1:0] iter;
  logic                       iter_last;

  assign iter_last = (iter == '0);

  always_comb begin
    ctrl = bdm_pkg::microcode(step);
  end

  always_comb begin
    step_next = step + 1'b1;
    case (ctrl.jump)
      bdm_pkg::JMP_NEXT:     step_next = step + 1'b1;
      bdm_pkg::JMP_WAIT_IN:  step_next = status.in_req ? step + 1'b1 : step;
      bdm_pkg::JMP_LOOP:     step_next = iter_last ? step + 1'b1 : step;
      bdm_pkg::JMP_SKIP:     step_next = status.rate_done ? ctrl.target : step + 1'b1;
      bdm_pkg::JMP_WAIT_OUT: step_next = status.out_free ? ctrl.target : step;
      bdm_pkg::JMP_GOTO:     step_next = ctrl.target;
      default:               step_next = bdm_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bdm_pkg::STEP_IDLE;
      iter <= '0;
    end else begin
      step <= step_next;
      if (ctrl.load_iter) begin
        iter <= ctrl.iter_init;
      end else if (ctrl.jump == bdm_pkg::JMP_LOOP && !iter_last) begin
        iter <= iter - 1'b1;
      end
    end
  end

endmodule

FILE: sv/bdm_datapath.sv
// Registers, multipliers and shared restoring divide step of the monitor.
module bdm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bdm_pkg::ctrl_word_t                 ctrl,
  output bdm_pkg::dp_status_t                 status,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bdm_pkg::bdm_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bdm_pkg::bdm_out_t                   out_data,
  input  logic                                cfg_valid,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdm_pkg::MV_W-1:0]            cfg_data
);

  // Configuration
  logic [bdm_pkg::MV_W-1:0]    full_mv;
  logic [bdm_pkg::MV_W-1:0]    empty_mv;
  logic [bdm_pkg::LIMIT_W-1:0] rise_limit;

  // Persistent tracking state
  logic [bdm_pkg::MV_W-1:0]   previous_mv;
  logic [bdm_pkg::RISE_W-1:0] rise_count;
  logic [bdm_pkg::MV_W-1:0]   reference_mv;
  logic [bdm_pkg::SEC_W-1:0]  reference_seconds;

  // Per-request working registers
  logic [bdm_pkg::RAW_W-1:0]   raw;
  logic [bdm_pkg::SEC_W-1:0]   now;
  logic [bdm_pkg::MV_W-1:0]    mv;
  logic [bdm_pkg::SEC_W-1:0]   elapsed;
  logic [bdm_pkg::MV_W-1:0]    span;
  logic [bdm_pkg::MV_W-1:0]    diff;
  logic                        level_low, level_high;
  logic                        charging, rate_invalid, rate_done, rate_sat;
  logic [bdm_pkg::LEVEL_W-1:0] level;
  logic [bdm_pkg::RATE_W-1:0]  rate;
  logic [bdm_pkg::DEN_W-1:0]   den;
  logic [bdm_pkg::REM_W-1:0]   rem;
  logic [bdm_pkg::REM_W-1:0]   dsh;
  logic [bdm_pkg::RATE_W-1:0]  quo;

  // Combinational terms
  logic [bdm_pkg::RAW_W+bdm_pkg::MV_W-1:0] mv_prod;
  logic [bdm_pkg::RISE_W-1:0]    rise_next;
  logic                          restart;
  logic [bdm_pkg::ELAPSED_W-1:0] elapsed_wide;
  logic [bdm_pkg::SPAN_W-1:0]    span_wide;
  logic [bdm_pkg::SPAN_W-1:0]    diff_wide;
  logic                          elapsed_pos, span_pos, diff_pos;
  logic [bdm_pkg::MV_W-1:0]      level_base;
  logic [bdm_pkg::MV_W+bdm_pkg::LEVEL_W-1:0] level_num;
  logic [bdm_pkg::DEN_W-1:0]     den_prod;
  logic [bdm_pkg::MV_W+23:0]     num_prod;
  logic                          div_take;
  logic                          out_free;

  assign mv_prod   = (bdm_pkg::RAW_W+bdm_pkg::MV_W)'(raw) * bdm_pkg::MV_SCALE;
  assign rise_next = (mv > previous_mv)
                   ? ((rise_count == bdm_pkg::RISE_MAX) ? rise_count : rise_count + 1'b1)
                   : '0;
  assign restart   = (rise_next > bdm_pkg::RISE_W'(rise_limit)) || (reference_mv == '0);

  assign elapsed_wide = {1'b0, now} - {1'b0, reference_seconds};
  assign span_wide    = {1'b0, full_mv} - {1'b0, empty_mv};
  assign diff_wide    = {1'b0, reference_mv} - {1'b0, mv};
  assign elapsed_pos  = !elapsed_wide[bdm_pkg::ELAPSED_W-1] && (elapsed_wide != '0);
  assign span_pos     = !span_wide[bdm_pkg::SPAN_W-1] && (span_wide != '0);
  assign diff_pos     = !diff_wide[bdm_pkg::SPAN_W-1] && (diff_wide != '0);

  assign level_base = mv - empty_mv;
  assign level_num  = (bdm_pkg::MV_W+bdm_pkg::LEVEL_W)'(level_base) * bdm_pkg::LEVEL_SCALE;
  assign den_prod   = bdm_pkg::DEN_W'(elapsed) * span;
  assign num_prod   = (bdm_pkg::MV_W+24)'(diff) * bdm_pkg::RATE_SCALE;
  assign div_take   = (rem >= dsh);

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (ctrl.op == bdm_pkg::OP_WAIT_IN);
  assign status    = '{in_req: in_valid, out_free: out_free, rate_done: rate_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mv    <= bdm_pkg::FULL_MV_RESET;
      empty_mv   <= bdm_pkg::EMPTY_MV_RESET;
      rise_limit <= bdm_pkg::RISE_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdm_pkg::REG_FULL_MV:    full_mv    <= cfg_data;
        bdm_pkg::REG_EMPTY_MV:   empty_mv   <= cfg_data;
        bdm_pkg::REG_RISE_LIMIT: rise_limit <= cfg_data[bdm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mv       <= '0;
      rise_count        <= '0;
      reference_mv      <= '0;
      reference_seconds <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (ctrl.op == bdm_pkg::OP_UPDATE) begin
        previous_mv <= mv;
        rise_count  <= rise_next;
        if (restart) begin
          reference_mv      <= mv;
          reference_seconds <= now;
        end
      end
      if (ctrl.op == bdm_pkg::OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      bdm_pkg::OP_WAIT_IN: begin
        if (in_valid) begin
          raw <= in_data.raw_sample;
          now <= in_data.now_seconds;
        end
      end
      bdm_pkg::OP_MV: begin
        mv <= mv_prod[bdm_pkg::MV_SHIFT +: bdm_pkg::MV_W];
      end
      bdm_pkg::OP_UPDATE: begin
        elapsed      <= elapsed_wide[bdm_pkg::SEC_W-1:0];
        span         <= span_wide[bdm_pkg::MV_W-1:0];
        diff         <= diff_wide[bdm_pkg::MV_W-1:0];
        level_low    <= (mv <= empty_mv);
        level_high   <= (mv >= full_mv);
        charging     <= restart;
        rate_invalid <= !restart && !(elapsed_pos && span_pos);
        rate_done    <= restart || !elapsed_pos || !span_pos || !diff_pos;
        rate         <= '0;
      end
      bdm_pkg::OP_LVL_LOAD: begin
        rem <= bdm_pkg::REM_W'(level_num);
        dsh <= bdm_pkg::REM_W'(span) << (bdm_pkg::LEVEL_W - 1);
        quo <= '0;
      end
      bdm_pkg::OP_DIV: begin
        if (div_take) begin
          rem <= rem - dsh;
        end
        quo <= {quo[bdm_pkg::RATE_W-2:0], div_take};
        dsh <= dsh >> 1;
      end
      bdm_pkg::OP_LVL_STORE: begin
        level <= level_low  ? '0 :
                 level_high ? bdm_pkg::LEVEL_MAX : quo[bdm_pkg::LEVEL_W-1:0];
      end
      bdm_pkg::OP_DEN_MUL: begin
        den <= den_prod;
      end
      bdm_pkg::OP_NUM_MUL: begin
        rem <= bdm_pkg::REM_W'(num_prod);
      end
      bdm_pkg::OP_RATE_LOAD: begin
        rate_sat <= (rem >= {den, bdm_pkg::RATE_W'(0)});
        dsh      <= bdm_pkg::REM_W'({den, (bdm_pkg::RATE_W-1)'(0)});
        quo      <= '0;
      end
      bdm_pkg::OP_RATE_STORE: begin
        rate <= rate_sat ? bdm_pkg::RATE_MAX : quo;
      end
      bdm_pkg::OP_EMIT: begin
        if (out_free) begin
          out_data <= '{voltage_mv:     mv,
                        level_percent:  level,
                        charging:       charging,
                        drain_rate:     rate,
                        rate_invalid:   rate_invalid};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/bdm_checker.sv
// Port-level checks for the battery discharge monitor, bound to the top level.
module bdm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  bdm_pkg::bdm_out_t               out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Drop ready after taking a request: one request in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // Level and voltage stay in range.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.level_percent <= bdm_pkg::LEVEL_MAX &&
                  out_data.voltage_mv <= bdm_pkg::MV_OUT_MAX)
    else $error("level or voltage out of range");

  // Charging and invalid results carry a zero rate and never both flags.
  a_flag_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.charging || out_data.rate_invalid) |->
      out_data.drain_rate == '0 && !(out_data.charging && out_data.rate_invalid))
    else $error("flagged result with nonzero rate or both flags");

endmodule

bind battery_discharge_monitor bdm_checker u_bdm_checker (.*);

FILE: verif/discharge_checker.sv
// Predicts battery monitor readings from the observed channels and compares them.
module discharge_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bdm_pkg::bdm_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bdm_pkg::bdm_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdm_pkg::MV_W-1:0]      cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int unsigned MV_PER_FULL_SCALE   = 4900;     // two times 2450 mV
  localparam int unsigned LEVELS_SHIFT        = 12;       // 4096 converter levels
  localparam longint      PCT_SECONDS_PER_DAY = 8640000;  // 100 percent * 86400 s
  localparam longint      RATE_CEILING        = 255;

  // Threshold registers as last written.
  logic [bdm_pkg::MV_W-1:0]    full_mv;
  logic [bdm_pkg::MV_W-1:0]    empty_mv;
  logic [bdm_pkg::LIMIT_W-1:0] rise_lim;

  // Battery history.
  logic [bdm_pkg::MV_W-1:0]    last_mv;
  logic [bdm_pkg::RISE_W-1:0]  rises;
  logic [bdm_pkg::MV_W-1:0]    anchor_mv;
  logic [bdm_pkg::SEC_W-1:0]   anchor_sec;

  bdm_pkg::bdm_out_t expected_readings[$];
  int                mismatches;

  assign errors = mismatches;

  task automatic flag(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic bdm_pkg::bdm_out_t predict_reading(input bdm_pkg::bdm_in_t s);
    bdm_pkg::bdm_out_t        r;
    logic [bdm_pkg::MV_W-1:0] mv;
    longint                   elapsed;
    longint                   span;
    longint                   quotient;
    r  = '0;
    mv = bdm_pkg::MV_W'((32'(s.raw_sample) * MV_PER_FULL_SCALE) >> LEVELS_SHIFT);
    r.voltage_mv = mv;

    if (mv <= empty_mv)
      r.level_percent = '0;
    else if (mv >= full_mv)
      r.level_percent = bdm_pkg::LEVEL_W'(100);
    else
      r.level_percent = bdm_pkg::LEVEL_W'((32'(mv - empty_mv) * 100) /
                                          32'(full_mv - empty_mv));

    if (mv > last_mv) begin
      if (rises != bdm_pkg::RISE_MAX)
        rises = rises + 1'b1;
    end else begin
      rises = '0;
    end

    if (rises > {1'b0, rise_lim} || anchor_mv == '0) begin
      anchor_mv  = mv;
      anchor_sec = s.now_seconds;
      r.charging = 1'b1;
    end else begin
      elapsed = longint'(s.now_seconds) - longint'(anchor_sec);
      span    = longint'(full_mv) - longint'(empty_mv);
      if (elapsed <= 0 || span <= 0) begin
        r.rate_invalid = 1'b1;
      end else begin
        quotient = ((longint'(anchor_mv) - longint'(mv)) * PCT_SECONDS_PER_DAY) /
                   (elapsed * span);
        if (quotient < 0)
          quotient = 0;
        if (quotient > RATE_CEILING)
          quotient = RATE_CEILING;
        r.drain_rate = bdm_pkg::RATE_W'(quotient);
      end
    end
    last_mv = mv;
    return r;
  endfunction

  always @(posedge clk) begin
    bdm_pkg::bdm_out_t want;
    if (rst) begin
      full_mv    = bdm_pkg::FULL_MV_RESET;
      empty_mv   = bdm_pkg::EMPTY_MV_RESET;
      rise_lim   = bdm_pkg::RISE_LIMIT_RESET;
      last_mv    = '0;
      rises      = '0;
      anchor_mv  = '0;
      anchor_sec = '0;
      expected_readings.delete();
    end else begin
      // Check results first: a result never belongs to a request taken at the same edge.
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          flag("result with nothing expected", 1, 0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data.voltage_mv !== want.voltage_mv)
            flag("voltage_mv", out_data.voltage_mv, want.voltage_mv);
          if (out_data.level_percent !== want.level_percent)
            flag("level_percent", out_data.level_percent, want.level_percent);
          if (out_data.charging !== want.charging)
            flag("charging", out_data.charging, want.charging);
          if (out_data.drain_rate !== want.drain_rate)
            flag("drain_rate", out_data.drain_rate, want.drain_rate);
          if (out_data.rate_invalid !== want.rate_invalid)
            flag("rate_invalid", out_data.rate_invalid, want.rate_invalid);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (bdm_pkg::cfg_reg_t'(cfg_index))
          bdm_pkg::REG_FULL_MV:    full_mv  = cfg_data;
          bdm_pkg::REG_EMPTY_MV:   empty_mv = cfg_data;
          bdm_pkg::REG_RISE_LIMIT: rise_lim = cfg_data[bdm_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(predict_reading(in_data));
    end
    pending <= expected_readings.size();
  end

endmodule

FILE: verif/tb_top.sv
// Stimulus and verdict for the battery discharge monitor.
module tb_top;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 30;   // longer than the rate path of one request
  localparam int PHASE_REQUESTS = 135;
  localparam int IDLE_PERCENT   = 18;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  bdm_pkg::bdm_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  bdm_pkg::bdm_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index = bdm_pkg::REG_FULL_MV;
  logic [bdm_pkg::MV_W-1:0]      cfg_data = '0;

  int  errors;
  int  pending;
  int  cycle_count = 0;
  bit  calm = 1'b0;        // when set, neither side idles

  battery_discharge_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  discharge_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side now and then, except during calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one sample request and hold it until taken. Valid stays high on
  // return so back-to-back requests need no low cycle; drop it only ahead
  // of an idle gap.
  task automatic offer_sample(input logic [bdm_pkg::RAW_W-1:0] raw,
                              input logic [bdm_pkg::SEC_W-1:0] secs);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
      gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.raw_sample   <= raw;
    in_data.now_seconds  <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding reading, then let the sequencer
  // run out before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three thresholds, holding valid across the three writes.
  task automatic program_thresholds(input logic [bdm_pkg::MV_W-1:0] full,
                                    input logic [bdm_pkg::MV_W-1:0] empty,
                                    input logic [bdm_pkg::LIMIT_W-1:0] limit);
    bdm_pkg::cfg_reg_t        idx[3];
    logic [bdm_pkg::MV_W-1:0] val[3];
    idx[0] = bdm_pkg::REG_FULL_MV;    val[0] = full;
    idx[1] = bdm_pkg::REG_EMPTY_MV;   val[1] = empty;
    idx[2] = bdm_pkg::REG_RISE_LIMIT; val[2] = bdm_pkg::MV_W'(limit);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly plausible battery life: slow discharge with advancing time, and
  // charging ramps long enough to trip any rise limit and saturate the
  // counter. The rest is stale or backward time and wild samples.
  task automatic run_traffic(input int count);
    int          lvl;
    int          ramp;
    int          pick;
    int unsigned secs;
    lvl  = $urandom_range(1900, 4095);
    secs = $urandom;
    ramp = 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (ramp == 0 && pick >= 65 && pick < 75)
        ramp = $urandom_range(2, 36);
      if (ramp > 0) begin
        lvl  = lvl + $urandom_range(1, 20);
        secs = secs + $urandom_range(1, 600);
        ramp--;
      end else if (pick < 75) begin
        lvl  = lvl - $urandom_range(0, 12);
        secs = secs + $urandom_range(1, 50000);
      end else if (pick < 85) begin
        secs = secs - $urandom_range(0, 3);
      end else begin
        lvl  = $urandom_range(0, 4095);
        secs = $urandom;
      end
      if (lvl > 4095) lvl = 4095;
      if (lvl < 0) lvl = 0;
      offer_sample(bdm_pkg::RAW_W'(lvl), secs);
    end
  endtask

  initial begin
    logic [bdm_pkg::SEC_W-1:0] t0;
    t0 = 32'd1000000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass on the reset thresholds.
    offer_sample(12'd0, 32'd0);               // zero volts: restart, no reference kept
    offer_sample(12'd0, 32'hFFFF_FFFF);       // restart again
    offer_sample(12'd4095, 32'd0);            // top of scale, reference taken
    offer_sample(12'd4095, 32'd0);            // no elapsed time
    offer_sample(12'd4095, 32'hFFFF_FFFF);    // longest elapsed time, no drop
    offer_sample(12'd1923, 32'd86400);        // exactly empty, rate clamps high
    offer_sample(12'd1922, 32'd172800);       // below empty
    offer_sample(12'd2000, 32'd259200);       // rising once, still discharging
    offer_sample(12'd2424, 32'd259300);       // just under full
    offer_sample(12'd2425, 32'd259400);       // just over full
    offer_sample(12'd2500, t0);
    offer_sample(12'd2600, t0);               // rise count at the limit
    offer_sample(12'd2700, t0);               // past the limit: restart
    offer_sample(12'd2800, t0 + 100);         // still rising: restart again
    offer_sample(12'd2790, t0 + 200);         // small drop, rate still clamps high
    offer_sample(12'd2900, t0 + 300);         // above reference, rate clamps to zero
    offer_sample(12'd2850, t0 + 95);          // before the reference time
    offer_sample(12'd2000, t0 + 3700);
    offer_sample(12'd0, t0 + 7300);           // collapse to zero volts
    offer_sample(12'd4095, 32'hFFFF_FFFF);
    offer_sample(12'd1, 32'd0);               // wrapped time, backward
    settle();

    // Threshold phases, extremes included.
    program_thresholds(13'd2900, 13'd2300, 4'd5);
    run_traffic(PHASE_REQUESTS);
    settle();

    program_thresholds(13'd8191, 13'd0, 4'd15);
    run_traffic(PHASE_REQUESTS);
    settle();

    program_thresholds(13'd0, 13'd0, 4'd0);       // no span: every non-charging rate invalid
    run_traffic(PHASE_REQUESTS);
    settle();

    program_thresholds(13'd2000, 13'd3000, 4'd3); // full below empty
    run_traffic(PHASE_REQUESTS);
    settle();

    // Hold both sides busy for a whole phase.
    calm <= 1'b1;
    program_thresholds(13'd2601, 13'd2600, 4'd1); // one-millivolt span
    run_traffic(PHASE_REQUESTS);
    settle();
    calm <= 1'b0;

    begin
      logic [bdm_pkg::MV_W-1:0] f;
      f = bdm_pkg::MV_W'($urandom_range(1000, 4898));
      program_thresholds(f, f - bdm_pkg::MV_W'($urandom_range(1, 1000)),
                         bdm_pkg::LIMIT_W'($urandom_range(0, 15)));
    end
    run_traffic(PHASE_REQUESTS);
    settle();

    program_thresholds(bdm_pkg::MV_W'($urandom), bdm_pkg::MV_W'($urandom),
                       bdm_pkg::LIMIT_W'($urandom));
    run_traffic(PHASE_REQUESTS);
    settle();

    program_thresholds(13'd4898, 13'd4000, 4'd10);
    run_traffic(PHASE_REQUESTS);
    settle();

    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
